// File: hdl/dflc_pkg.sv
// Shared types and constants for the delimited frame link controller.
// No dependencies; the ALU, the controller and the testbench import this package.
`timescale 1ns / 1ps

package dflc_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RESULT_CAP = 32;

  // Register defaults after reset
  localparam logic [7:0]  START_CHAR_RST = 8'd60;
  localparam logic [7:0]  END_CHAR_RST   = 8'd62;
  localparam logic [15:0] TICK_STEP_RST  = 16'd10;
  localparam logic [15:0] RX_TMO_RST     = 16'd1000;
  localparam logic [15:0] TX_TMO_RST     = 16'd1000;

  typedef enum logic [1:0] {
    LINK_IDLE = 2'd0,
    LINK_RX   = 2'd1,
    LINK_TX   = 2'd2
  } link_state_e;

  typedef enum logic [1:0] {
    MODE_RX_BYTE = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_LOAD    = 2'd2
  } in_mode_e;

  typedef enum logic [1:0] {
    KIND_STATUS     = 2'd0,
    KIND_TX_BYTE    = 2'd1,
    KIND_FRAME_BYTE = 2'd2,
    KIND_DISCARD    = 2'd3
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CHAR = 3'd0,
    CFG_END_CHAR   = 3'd1,
    CFG_TICK_STEP  = 3'd2,
    CFG_RX_TIMEOUT = 3'd3,
    CFG_TX_TIMEOUT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEQ_IDLE    = 3'd0,
    SEQ_TICK    = 3'd1,
    SEQ_ELAPSED = 3'd2,
    SEQ_CMP     = 3'd3,
    SEQ_EXEC    = 3'd4,
    SEQ_FRD     = 3'd5,
    SEQ_FOUT    = 3'd6
  } seq_state_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [TIME_W-1:0]  a;
    logic [TIME_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]  sum;
    logic               carry;
  } alu_rsp_t;

  typedef struct packed {
    res_kind_e    kind;
    logic [7:0]   out_byte;
    logic         frame_last;
    logic [5:0]   frame_length;
    link_state_e  machine_state;
    logic         drive_enable;
    logic         send_pending;
    logic         last;
  } res_t;

endpackage

// File: hdl/dflc_if.sv
// Valid/ready channel interfaces for the input items and the result beats.
// Standalone; payload widths follow the block's item and result fields.
`timescale 1ns / 1ps

interface dflc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data;
  logic       load_last;

  modport source (output valid, mode, data, load_last, input ready);
  modport sink   (input valid, mode, data, load_last, output ready);
endinterface

interface dflc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       frame_last;
  logic [5:0] frame_length;
  logic [1:0] machine_state;
  logic       drive_enable;
  logic       send_pending;
  logic       last;

  modport source (output valid, result_kind, out_byte, frame_last, frame_length,
                  machine_state, drive_enable, send_pending, last, input ready);
  modport sink   (input valid, result_kind, out_byte, frame_last, frame_length,
                  machine_state, drive_enable, send_pending, last, output ready);
endinterface

// File: hdl/dflc_alu.sv
// Shared 32-bit add/subtract unit used for time keeping and timeout checks.
// Depends on dflc_pkg for the request and response structs.
`timescale 1ns / 1ps

module dflc_alu import dflc_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [TIME_W:0]   acc;
  logic [TIME_W-1:0] b_op;
  logic              cin;

  // Subtract is a + ~b + 1; carry out set means a >= b
  always_comb begin
    case (req_i.op)
      ALU_ADD: begin
        b_op = req_i.b;
        cin  = 1'b0;
      end
      ALU_SUB: begin
        b_op = ~req_i.b;
        cin  = 1'b1;
      end
      default: begin
        b_op = req_i.b;
        cin  = 1'b0;
      end
    endcase
    acc = {1'b0, req_i.a} + {1'b0, b_op} + (TIME_W+1)'(cin);
  end

  assign rsp_o.sum   = acc[TIME_W-1:0];
  assign rsp_o.carry = acc[TIME_W];

endmodule

// File: hdl/delimited_frame_link_controller.sv
// Sequencing: an item is accepted in idle, then passes four sequencer steps (time add,
// elapsed subtract, timeout compare, state update), the first three through the shared
// adder; the input is not ready for a new item until the sequencer is back in idle.
// A tick that delivers a frame adds a buffer read and an output load per frame byte.
// Output stalls hold the update and delivery steps. Reset (async, active low) clears
// all control state and loads register defaults; the byte buffers are not cleared.
`timescale 1ns / 1ps

module delimited_frame_link_controller import dflc_pkg::*; #(
  parameter int RX_DEPTH = 32,
  parameter int TX_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dflc_in_if.sink               in_i,
  dflc_out_if.source            out_o
);

  localparam int RXC_W = $clog2(RX_DEPTH + 1);
  localparam int TXC_W = $clog2(TX_DEPTH + 1);
  localparam int RXA_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TXA_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // Configuration registers
  logic [7:0]  start_char_q, end_char_q;
  logic [15:0] tick_step_q, rx_tmo_q, tx_tmo_q;

  // Sequencer and latched item
  seq_state_e  state_q, state_d;
  logic [1:0]  mode_q;
  logic [7:0]  data_q;
  logic        ll_q;

  // Link state
  logic [TIME_W-1:0] time_q, time_d, rx_start_q, rx_start_d, tx_start_q, tx_start_d;
  logic [TIME_W-1:0] diff_q, diff_d;
  logic              late_q, late_d;
  link_state_e       link_q, link_d;
  logic [RXC_W-1:0]  rx_cnt_q, rx_cnt_d, idx_q, idx_d;
  logic              rx_done_q, rx_done_d, rx_fault_q, rx_fault_d;
  logic [TXC_W-1:0]  tx_len_q, tx_len_d, tx_pos_q, tx_pos_d, tx_pos_n;
  logic              tx_req_q, tx_req_d, tx_fault_q, tx_fault_d, tx_fault_n;
  logic              drv_q, drv_d;

  // Output register
  logic  out_valid_q, out_valid_d, out_free;
  res_t  res_q, res_d;
  res_kind_e   kind_n;
  logic [7:0]  byte_n;
  logic        deliver_n, frame_fin;

  // Buffers
  logic [7:0]  rx_mem [RX_DEPTH];
  logic [7:0]  tx_mem [TX_DEPTH];
  logic [7:0]  rx_rd_q, tx_rd_q;
  logic        rx_we, rx_re, tx_we, tx_re;

  // Shared adder
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  dflc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= START_CHAR_RST;
      end_char_q   <= END_CHAR_RST;
      tick_step_q  <= TICK_STEP_RST;
      rx_tmo_q     <= RX_TMO_RST;
      tx_tmo_q     <= TX_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_CHAR: start_char_q <= cfg_wdata_i[7:0];
        CFG_END_CHAR:   end_char_q   <= cfg_wdata_i[7:0];
        CFG_TICK_STEP:  tick_step_q  <= cfg_wdata_i;
        CFG_RX_TIMEOUT: rx_tmo_q     <= cfg_wdata_i;
        CFG_TX_TIMEOUT: tx_tmo_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == SEQ_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign frame_fin  = ((idx_q + RXC_W'(1)) == rx_cnt_q) || (32'(idx_q) == RESULT_CAP - 1);

  // Adder operands per sequencer step
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = time_q;
    alu_req.b  = {16'd0, tick_step_q};
    case (state_q)
      SEQ_ELAPSED: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = (link_q == LINK_TX) ? tx_start_q : rx_start_q;
      end
      SEQ_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {16'd0, (link_q == LINK_TX) ? tx_tmo_q : rx_tmo_q};
        alu_req.b  = diff_q;
      end
      default: ;
    endcase
  end

  // Sequencer: next state, link updates and result beats
  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    rx_start_d  = rx_start_q;
    tx_start_d  = tx_start_q;
    diff_d      = diff_q;
    late_d      = late_q;
    link_d      = link_q;
    rx_cnt_d    = rx_cnt_q;
    idx_d       = idx_q;
    rx_done_d   = rx_done_q;
    rx_fault_d  = rx_fault_q;
    tx_len_d    = tx_len_q;
    tx_pos_d    = tx_pos_q;
    tx_req_d    = tx_req_q;
    tx_fault_d  = tx_fault_q;
    drv_d       = drv_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    kind_n      = KIND_STATUS;
    byte_n      = 8'd0;
    deliver_n   = 1'b0;
    tx_pos_n    = tx_pos_q;
    tx_fault_n  = tx_fault_q;

    case (state_q)
      SEQ_IDLE: begin
        if (in_i.valid) state_d = SEQ_TICK;
      end

      SEQ_TICK: begin
        if (mode_q == MODE_TICK) time_d = alu_rsp.sum;
        state_d = SEQ_ELAPSED;
      end

      SEQ_ELAPSED: begin
        diff_d = alu_rsp.sum;
        // fetch the next byte to send ahead of the update step
        tx_re   = (link_q == LINK_TX) && (tx_pos_q < TXC_W'(TX_DEPTH));
        state_d = SEQ_CMP;
      end

      SEQ_CMP: begin
        late_d  = !alu_rsp.carry;
        state_d = SEQ_EXEC;
      end

      SEQ_EXEC: begin
        if (out_free) begin
          case (mode_q)
            MODE_RX_BYTE: begin
              case (link_q)
                LINK_IDLE: begin
                  if (data_q == start_char_q) begin
                    link_d     = LINK_RX;
                    rx_start_d = time_q;
                    rx_done_d  = 1'b0;
                    rx_fault_d = 1'b0;
                    rx_cnt_d   = '0;
                  end
                end
                LINK_RX: begin
                  if (data_q == end_char_q) begin
                    rx_done_d = 1'b1;
                  end else if (late_q || (rx_cnt_q >= RXC_W'(RX_DEPTH))) begin
                    rx_fault_d = 1'b1;
                  end else begin
                    rx_we    = 1'b1;
                    rx_cnt_d = rx_cnt_q + RXC_W'(1);
                  end
                end
                default: begin
                  // byte on the line aborts a send
                  link_d   = LINK_IDLE;
                  drv_d    = 1'b0;
                  tx_pos_d = '0;
                  tx_req_d = 1'b0;
                  tx_len_d = '0;
                end
              endcase
            end

            MODE_TICK: begin
              case (link_q)
                LINK_IDLE: begin
                  if (rx_fault_q) begin
                    rx_fault_d = 1'b0;
                    kind_n     = KIND_DISCARD;
                  end else if (rx_done_q) begin
                    rx_done_d = 1'b0;
                    deliver_n = (rx_cnt_q != '0);
                  end else if (tx_fault_q) begin
                    tx_fault_d = 1'b0;
                    kind_n     = KIND_DISCARD;
                  end
                  if (tx_req_q) begin
                    drv_d      = 1'b1;
                    link_d     = LINK_TX;
                    tx_start_d = time_q;
                    tx_pos_d   = '0;
                    tx_fault_d = 1'b0;
                  end
                end
                LINK_RX: begin
                  rx_fault_d = rx_fault_q | late_q;
                  if (rx_done_q || rx_fault_q || late_q) begin
                    link_d   = LINK_IDLE;
                    drv_d    = 1'b0;
                    tx_pos_d = '0;
                  end
                end
                default: begin
                  if ((tx_pos_q < tx_len_q) && (tx_pos_q < TXC_W'(TX_DEPTH))) begin
                    kind_n   = KIND_TX_BYTE;
                    byte_n   = tx_rd_q;
                    tx_pos_n = tx_pos_q + TXC_W'(1);
                  end
                  tx_fault_n = tx_fault_q | late_q;
                  tx_fault_d = tx_fault_n;
                  tx_pos_d   = tx_pos_n;
                  if ((tx_pos_n == tx_len_q) || tx_fault_n) begin
                    link_d   = LINK_IDLE;
                    drv_d    = 1'b0;
                    tx_pos_d = '0;
                    tx_req_d = 1'b0;
                    tx_len_d = '0;
                  end
                end
              endcase
            end

            MODE_LOAD: begin
              if (!tx_req_q) begin
                if (tx_len_q < TXC_W'(TX_DEPTH)) begin
                  tx_we    = 1'b1;
                  tx_len_d = tx_len_q + TXC_W'(1);
                end
                if (ll_q) tx_req_d = 1'b1;
              end
            end

            default: ;
          endcase

          if (deliver_n) begin
            idx_d   = '0;
            state_d = SEQ_FRD;
          end else begin
            out_valid_d         = 1'b1;
            res_d.kind          = kind_n;
            res_d.out_byte      = byte_n;
            res_d.frame_last    = 1'b0;
            res_d.frame_length  = '0;
            res_d.machine_state = link_d;
            res_d.drive_enable  = drv_d;
            res_d.send_pending  = tx_req_d;
            res_d.last          = 1'b1;
            state_d             = SEQ_IDLE;
          end
        end
      end

      SEQ_FRD: begin
        rx_re   = 1'b1;
        state_d = SEQ_FOUT;
      end

      SEQ_FOUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.kind          = KIND_FRAME_BYTE;
          res_d.out_byte      = rx_rd_q;
          res_d.frame_last    = ((idx_q + RXC_W'(1)) == rx_cnt_q);
          res_d.frame_length  = 6'(rx_cnt_q);
          res_d.machine_state = link_q;
          res_d.drive_enable  = drv_q;
          res_d.send_pending  = tx_req_q;
          res_d.last          = frame_fin;
          if (frame_fin) begin
            state_d = SEQ_IDLE;
          end else begin
            idx_d   = idx_q + RXC_W'(1);
            state_d = SEQ_FRD;
          end
        end
      end

      default: state_d = SEQ_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      time_q      <= '0;
      rx_start_q  <= '0;
      tx_start_q  <= '0;
      link_q      <= LINK_IDLE;
      rx_cnt_q    <= '0;
      idx_q       <= '0;
      rx_done_q   <= 1'b0;
      rx_fault_q  <= 1'b0;
      tx_len_q    <= '0;
      tx_pos_q    <= '0;
      tx_req_q    <= 1'b0;
      tx_fault_q  <= 1'b0;
      drv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      rx_start_q  <= rx_start_d;
      tx_start_q  <= tx_start_d;
      link_q      <= link_d;
      rx_cnt_q    <= rx_cnt_d;
      idx_q       <= idx_d;
      rx_done_q   <= rx_done_d;
      rx_fault_q  <= rx_fault_d;
      tx_len_q    <= tx_len_d;
      tx_pos_q    <= tx_pos_d;
      tx_req_q    <= tx_req_d;
      tx_fault_q  <= tx_fault_d;
      drv_q       <= drv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: latched item, step results, result beat
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      data_q <= in_i.data;
      ll_q   <= in_i.load_last;
    end
    diff_q <= diff_d;
    late_q <= late_d;
    res_q  <= res_d;
  end

  // Receive buffer
  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_cnt_q[RXA_W-1:0]] <= data_q;
    if (rx_re) rx_rd_q <= rx_mem[idx_q[RXA_W-1:0]];
  end

  // Send buffer
  always_ff @(posedge clk_i) begin
    if (tx_we) tx_mem[tx_len_q[TXA_W-1:0]] <= data_q;
    if (tx_re) tx_rd_q <= tx_mem[tx_pos_q[TXA_W-1:0]];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = res_q.kind;
  assign out_o.out_byte      = res_q.out_byte;
  assign out_o.frame_last    = res_q.frame_last;
  assign out_o.frame_length  = res_q.frame_length;
  assign out_o.machine_state = res_q.machine_state;
  assign out_o.drive_enable  = res_q.drive_enable;
  assign out_o.send_pending  = res_q.send_pending;
  assign out_o.last          = res_q.last;

  // Checks
  a_accept_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == SEQ_TICK))
    else $error("sequencer did not start after an input beat");

  a_driver_tracks_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_q == (link_q == LINK_TX))
    else $error("line driver out of step with sending state");

  a_tx_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_pos_q <= tx_len_q)
    else $error("send position past send length");

  a_rx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= RXC_W'(RX_DEPTH))
    else $error("receive count past buffer depth");

endmodule

// File: sim/tb_delimited_frame_link_controller.sv
// Self-checking testbench for the delimited frame link controller: directed and random
// receive, tick and load beats checked against an in-bench scoreboard. Needs dflc_pkg,
// the dflc_in_if/dflc_out_if interfaces and the controller RTL.
`timescale 1ns / 1ps

module tb_delimited_frame_link_controller import dflc_pkg::*; ();

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 10;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Scoreboard: tracks link state and queues the beats each input beat should produce
  class link_scoreboard;
    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 32;

    // register copies
    logic [7:0]  start_char, end_char;
    logic [15:0] tick_step, rx_limit, tx_limit;

    // link state
    link_state_e link;
    logic [31:0] now, rx_t0, tx_t0;
    logic [7:0]  rx_buf [RX_DEPTH];
    logic [7:0]  tx_buf [TX_DEPTH];
    int          rx_cnt, tx_len, tx_pos;
    bit          rx_done, rx_fault, tx_req, tx_fault, drv_on;

    res_t pending [$];
    int   errors;
    int   beats_checked;

    function new();
      start_char = START_CHAR_RST;
      end_char   = END_CHAR_RST;
      tick_step  = TICK_STEP_RST;
      rx_limit   = RX_TMO_RST;
      tx_limit   = TX_TMO_RST;
      link       = LINK_IDLE;
      now        = '0;
      rx_t0      = '0;
      tx_t0      = '0;
      rx_cnt     = 0;
      tx_len     = 0;
      tx_pos     = 0;
      rx_done    = 0;
      rx_fault   = 0;
      tx_req     = 0;
      tx_fault   = 0;
      drv_on     = 0;
      errors     = 0;
      beats_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_START_CHAR: start_char = value[7:0];
        CFG_END_CHAR:   end_char   = value[7:0];
        CFG_TICK_STEP:  tick_step  = value;
        CFG_RX_TIMEOUT: rx_limit   = value;
        CFG_TX_TIMEOUT: tx_limit   = value;
        default: ;
      endcase
    endfunction

    function res_t make_beat(res_kind_e kind, logic [7:0] b, logic flast, logic [5:0] flen);
      res_t r;
      r              = '0;
      r.kind         = kind;
      r.out_byte     = b;
      r.frame_last   = flast;
      r.frame_length = flen;
      return r;
    endfunction

    function void drop_to_idle();
      link   = LINK_IDLE;
      drv_on = 0;
      tx_pos = 0;
    endfunction

    function void end_send();
      drop_to_idle();
      tx_req = 0;
      tx_len = 0;
    endfunction

    // Advance the link by one accepted input beat and queue its result beats
    function void note_item(logic [1:0] mode, logic [7:0] d, logic ll);
      res_t fresh [$];
      res_t b;
      logic [31:0] elapsed;
      case (mode)
        MODE_RX_BYTE: begin
          if (link == LINK_IDLE) begin
            if (d == start_char) begin
              link     = LINK_RX;
              rx_t0    = now;
              rx_done  = 0;
              rx_fault = 0;
              rx_cnt   = 0;
            end
          end else if (link == LINK_RX) begin
            elapsed = now - rx_t0;
            if (d == end_char) rx_done = 1;
            else if (elapsed > {16'd0, rx_limit}) rx_fault = 1;
            else if (rx_cnt >= RX_DEPTH) rx_fault = 1;
            else begin
              rx_buf[rx_cnt] = d;
              rx_cnt++;
            end
          end else begin
            // any received byte aborts a send
            end_send();
          end
        end
        MODE_TICK: begin
          now = now + {16'd0, tick_step};
          if (link == LINK_IDLE) begin
            // discard rx error, else deliver frame, else discard tx error
            if (rx_fault) begin
              rx_fault = 0;
              fresh.push_back(make_beat(KIND_DISCARD, 8'h00, 1'b0, 6'd0));
            end else if (rx_done) begin
              for (int i = 0; i < rx_cnt; i++)
                fresh.push_back(make_beat(KIND_FRAME_BYTE, rx_buf[i], i == rx_cnt - 1,
                                          6'(rx_cnt)));
              rx_done = 0;
            end else if (tx_fault) begin
              tx_fault = 0;
              fresh.push_back(make_beat(KIND_DISCARD, 8'h00, 1'b0, 6'd0));
            end
            if (tx_req) begin
              drv_on   = 1;
              link     = LINK_TX;
              tx_t0    = now;
              tx_pos   = 0;
              tx_fault = 0;
            end
          end else if (link == LINK_RX) begin
            elapsed = now - rx_t0;
            if (elapsed > {16'd0, rx_limit}) rx_fault = 1;
            if (rx_done || rx_fault) drop_to_idle();
          end else begin
            if (tx_pos < tx_len) begin
              fresh.push_back(make_beat(KIND_TX_BYTE, tx_buf[tx_pos], 1'b0, 6'd0));
              tx_pos++;
            end
            elapsed = now - tx_t0;
            if (elapsed > {16'd0, tx_limit}) tx_fault = 1;
            if (tx_pos == tx_len || tx_fault) end_send();
          end
        end
        MODE_LOAD: begin
          if (!tx_req) begin
            if (tx_len < TX_DEPTH) begin
              tx_buf[tx_len] = d;
              tx_len++;
            end
            if (ll) tx_req = 1;
          end
        end
        default: ;
      endcase

      if (fresh.size() == 0) fresh.push_back(make_beat(KIND_STATUS, 8'h00, 1'b0, 6'd0));

      // status fields reflect the state after this beat
      for (int k = 0; k < fresh.size(); k++) begin
        b               = fresh[k];
        b.machine_state = link;
        b.drive_enable  = drv_on;
        b.send_pending  = tx_req;
        b.last          = (k == fresh.size() - 1);
        pending.push_back(b);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("beat %0d %s: got %0h, want %0h",
                                  beats_checked, name, got, want));
    endtask

    task check_beat(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: kind %0d byte %02h",
                                  got.kind, got.out_byte));
      end else begin
        want = pending.pop_front();
        compare_field("result_kind",   got.kind,          want.kind);
        compare_field("out_byte",      got.out_byte,      want.out_byte);
        compare_field("frame_last",    got.frame_last,    want.frame_last);
        compare_field("frame_length",  got.frame_length,  want.frame_length);
        compare_field("machine_state", got.machine_state, want.machine_state);
        compare_field("drive_enable",  got.drive_enable,  want.drive_enable);
        compare_field("send_pending",  got.send_pending,  want.send_pending);
        compare_field("last",          got.last,          want.last);
        beats_checked++;
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dflc_in_if  in_ch ();
  dflc_out_if out_ch ();

  link_scoreboard sb;
  int items_sent = 0;
  int stall_cycles = 0;
  bit idling_on = 1'b1;
  bit hold_req = 1'b0;

  delimited_frame_link_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Monitor: check result beats, feed accepted input beats, and watch for a hang
  always @(posedge clk_i) begin : monitor
    res_t seen;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        seen.kind          = res_kind_e'(out_ch.result_kind);
        seen.out_byte      = out_ch.out_byte;
        seen.frame_last    = out_ch.frame_last;
        seen.frame_length  = out_ch.frame_length;
        seen.machine_state = link_state_e'(out_ch.machine_state);
        seen.drive_enable  = out_ch.drive_enable;
        seen.send_pending  = out_ch.send_pending;
        seen.last          = out_ch.last;
        sb.check_beat(seen);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(in_ch.mode, in_ch.data, in_ch.load_last);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int burst;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one beat and hold it until accepted; maybe idle afterwards
  task automatic drive_item(logic [1:0] m, logic [7:0] d, logic ll);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data      <= d;
    in_ch.load_last <= ll;
    do @(posedge clk_i); while (!in_ch.ready);
    if (m != MODE_UNUSED) items_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drive_tick();
    drive_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(logic [7:0] sc, logic [7:0] ec, logic [15:0] step,
                                logic [15:0] rx_tmo, logic [15:0] tx_tmo);
    write_reg(CFG_START_CHAR, {8'd0, sc});
    write_reg(CFG_END_CHAR,   {8'd0, ec});
    write_reg(CFG_TICK_STEP,  step);
    write_reg(CFG_RX_TIMEOUT, rx_tmo);
    write_reg(CFG_TX_TIMEOUT, tx_tmo);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering and wait until every expected beat has come out
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Start char, payload, usually an end char, then ticks to deliver
  task automatic send_frame();
    int len;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 34) : $urandom_range(0, 8);
    drive_item(MODE_RX_BYTE, sb.start_char, 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) drive_tick();
      b = 8'($urandom_range(0, 255));
      if (b == sb.end_char) b = b ^ 8'h01;
      drive_item(MODE_RX_BYTE, b, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) != 0)
      drive_item(MODE_RX_BYTE, sb.end_char, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 3)) drive_tick();
  endtask

  // Load a message, then tick it out; sometimes abort with a received byte
  task automatic send_message();
    int len;
    int ticks;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 34) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      drive_item(MODE_LOAD, 8'($urandom_range(0, 255)), i == len - 1);
    if ($urandom_range(0, 3) == 0)
      drive_item(MODE_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    ticks = len + 1 + $urandom_range(0, 1);
    for (int t = 0; t < ticks; t++) begin
      if (t == 2 && $urandom_range(0, 7) == 0)
        drive_item(MODE_RX_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      drive_tick();
    end
  endtask

  task automatic random_traffic(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_frame();
        5, 6, 7:       send_message();
        default: drive_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [7:0] sc, ec;
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_START_CHAR;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_RX_BYTE;
    in_ch.data       = 8'h00;
    in_ch.load_last  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats on reset settings
    drive_item(MODE_TICK, 8'h00, 1'b0);         // idle tick, nothing to do
    drive_item(MODE_UNUSED, 8'hFF, 1'b1);       // unused mode
    drive_item(MODE_RX_BYTE, 8'h00, 1'b0);      // idle, not a start char
    drive_item(MODE_RX_BYTE, sb.start_char, 1'b0);
    drive_item(MODE_RX_BYTE, 8'hFF, 1'b1);
    drive_item(MODE_RX_BYTE, 8'h00, 1'b0);
    drive_item(MODE_RX_BYTE, sb.end_char, 1'b0);
    drive_item(MODE_RX_BYTE, 8'hAA, 1'b0);      // after end char, still stored
    drive_item(MODE_TICK, 8'hFF, 1'b1);         // back to idle
    drive_item(MODE_TICK, 8'h00, 1'b0);         // frame delivery
    drive_item(MODE_RX_BYTE, sb.start_char, 1'b0);
    drive_item(MODE_RX_BYTE, sb.end_char, 1'b1);
    drive_item(MODE_TICK, 8'h00, 1'b0);
    drive_item(MODE_TICK, 8'h00, 1'b0);         // empty frame
    drive_item(MODE_LOAD, 8'h55, 1'b0);
    drive_item(MODE_LOAD, 8'hAA, 1'b1);
    drive_item(MODE_LOAD, 8'h12, 1'b1);         // ignored while request held
    drive_item(MODE_TICK, 8'h00, 1'b0);         // start sending
    drive_item(MODE_TICK, 8'h00, 1'b0);
    drive_item(MODE_TICK, 8'h00, 1'b0);         // last byte, leave sending
    drive_item(MODE_LOAD, 8'h01, 1'b1);
    drive_item(MODE_TICK, 8'h00, 1'b0);
    drive_item(MODE_RX_BYTE, sb.start_char, 1'b0);  // aborts the send
    drive_item(MODE_TICK, 8'h00, 1'b0);
    random_traffic(75);
    finish_phase();

    // Low extremes: every tick during a receive or a send times out
    apply_settings(8'h00, 8'hFF, 16'd1, 16'd0, 16'd0);
    random_traffic(75);
    finish_phase();

    // High extremes, with the receiver held off to back up the input
    apply_settings(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    random_traffic(75);
    finish_phase();

    // Random settings, short timeouts; start and end char sometimes equal
    repeat (2) begin
      sc = 8'($urandom_range(0, 255));
      ec = ($urandom_range(0, 3) == 0) ? sc : 8'($urandom_range(0, 255));
      apply_settings(sc, ec, 16'($urandom_range(1, 50)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 200)));
      random_traffic(55);
      finish_phase();
    end

    // Back to defaults at full rate
    idling_on = 1'b0;
    apply_settings(START_CHAR_RST, END_CHAR_RST, TICK_STEP_RST, RX_TMO_RST, TX_TMO_RST);
    random_traffic(55);
    finish_phase();

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
